FILE: hdl/assert_macros.svh
// assertion macros shared by the ubx frame receiver modules
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// condition holds in the same cycle as the trigger
`define ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");
// condition holds in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, trig, cond)
`define ASSERT_NEXT(label, clk, rst_n, trig, cond)
`endif
`endif

FILE: hdl/ubxfr_pkg.sv
// types, codes and helpers for the ubx frame receiver
// no dependencies
package ubxfr_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [15:0] MAX_LEN_RESET = 16'd248;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_MAX_LEN  = 2'd0;
    localparam logic [1:0] CFG_CK_EN    = 2'd1;
    localparam logic [1:0] CFG_CLASS_EN = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [3:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_CLASS,
        PH_ID,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CK_A,
        PH_CK_B
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SYNC     = 3'd1,
        ST_CLASS    = 3'd2,
        ST_CHECKSUM = 3'd3,
        ST_LENGTH   = 3'd4
    } t_status;

    typedef struct packed {
        logic [15:0] max_len;
        logic        ck_en;
        logic        class_en;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] payload_index;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_length;
        t_status     frame_status;
    } t_result;

    function automatic logic known_class(input logic [7:0] c);
        logic hit;
        case (c) inside
            8'h01, 8'h02, 8'h04, 8'h05, 8'h06, 8'h09, 8'h0A,
            8'h0B, 8'h0D, 8'h10, 8'h13, 8'h21, 8'h27, 8'h28: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

FILE: hdl/ubxfr_cfg_regs.sv
// configuration registers of the ubx frame receiver
// depends on ubxfr_pkg
module ubxfr_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_index,
    input  logic [15:0]        i_data,
    output logic               o_ready,
    output ubxfr_pkg::t_cfg    o_cfg
);

    ubxfr_pkg::t_cfg r_cfg;
    ubxfr_pkg::t_cfg n_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_valid) begin
            unique case (i_index)
                ubxfr_pkg::CFG_MAX_LEN:  n_cfg.max_len  = i_data;
                ubxfr_pkg::CFG_CK_EN:    n_cfg.ck_en    = i_data[0];
                ubxfr_pkg::CFG_CLASS_EN: n_cfg.class_en = i_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len  <= ubxfr_pkg::MAX_LEN_RESET;
            r_cfg.ck_en    <= 1'b1;
            r_cfg.class_en <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: hdl/ubxfr_decoder.sv
// byte register and frame state machine: sync hunt, header, payload, fletcher-8 check
// depends on ubxfr_pkg and assert_macros.svh
`include "assert_macros.svh"
module ubxfr_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  ubxfr_pkg::t_cfg     i_cfg,
    output logic                o_busy,
    output logic                o_res_valid,
    output ubxfr_pkg::t_result  o_res
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    ubxfr_pkg::t_phase r_phase, n_phase;
    logic [7:0]        r_class, n_class;
    logic [7:0]        r_id, n_id;
    logic [15:0]       r_len, n_len;
    logic [15:0]       r_count, n_count;
    logic [7:0]        r_sum_a, n_sum_a;
    logic [7:0]        r_sum_b, n_sum_b;
    logic [7:0]        r_rx_sum_a, n_rx_sum_a;

    logic [7:0]        add_a;
    logic [7:0]        add_b;
    logic [15:0]       full_len;
    logic              last_byte;

    assign o_busy   = r_in_valid;
    assign add_a    = r_sum_a + r_in_byte;
    assign add_b    = r_sum_b + add_a;
    assign full_len = {r_in_byte, r_len[7:0]};
    assign last_byte = ({1'b0, r_count} + 17'd1) >= {1'b0, r_len};

    always_comb begin
        n_phase     = r_phase;
        n_class     = r_class;
        n_id        = r_id;
        n_len       = r_len;
        n_count     = r_count;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_rx_sum_a  = r_rx_sum_a;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (r_in_valid) begin
            unique case (r_phase)
                ubxfr_pkg::PH_SYNC1: begin
                    n_phase = (r_in_byte == ubxfr_pkg::SYNC_FIRST) ?
                              ubxfr_pkg::PH_SYNC2 : ubxfr_pkg::PH_SYNC1;
                end
                ubxfr_pkg::PH_SYNC2: begin
                    if (r_in_byte == ubxfr_pkg::SYNC_SECOND) begin
                        n_phase = ubxfr_pkg::PH_CLASS;
                    end else begin
                        // a repeated first sync byte starts a new hunt at once
                        n_phase = (r_in_byte == ubxfr_pkg::SYNC_FIRST) ?
                                  ubxfr_pkg::PH_SYNC2 : ubxfr_pkg::PH_SYNC1;
                        o_res_valid        = 1'b1;
                        o_res.kind         = ubxfr_pkg::KIND_STATUS;
                        o_res.frame_status = ubxfr_pkg::ST_SYNC;
                    end
                end
                ubxfr_pkg::PH_CLASS: begin
                    n_class = r_in_byte;
                    n_id    = '0;
                    n_len   = '0;
                    n_count = '0;
                    n_sum_a = r_in_byte;
                    n_sum_b = r_in_byte;
                    if (i_cfg.class_en && !ubxfr_pkg::known_class(r_in_byte)) begin
                        n_phase            = ubxfr_pkg::PH_SYNC1;
                        o_res_valid        = 1'b1;
                        o_res.kind         = ubxfr_pkg::KIND_STATUS;
                        o_res.msg_class    = r_in_byte;
                        o_res.frame_status = ubxfr_pkg::ST_CLASS;
                    end else begin
                        n_phase = ubxfr_pkg::PH_ID;
                    end
                end
                ubxfr_pkg::PH_ID: begin
                    n_id    = r_in_byte;
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = ubxfr_pkg::PH_LEN_LO;
                end
                ubxfr_pkg::PH_LEN_LO: begin
                    n_len   = {8'h00, r_in_byte};
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = ubxfr_pkg::PH_LEN_HI;
                end
                ubxfr_pkg::PH_LEN_HI: begin
                    n_len   = full_len;
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    if (full_len > i_cfg.max_len) begin
                        n_phase              = ubxfr_pkg::PH_SYNC1;
                        o_res_valid          = 1'b1;
                        o_res.kind           = ubxfr_pkg::KIND_STATUS;
                        o_res.msg_class      = r_class;
                        o_res.msg_id         = r_id;
                        o_res.payload_length = full_len;
                        o_res.frame_status   = ubxfr_pkg::ST_LENGTH;
                    end else if (full_len == '0) begin
                        n_phase = ubxfr_pkg::PH_CK_A;
                    end else begin
                        n_phase = ubxfr_pkg::PH_PAYLOAD;
                    end
                end
                ubxfr_pkg::PH_PAYLOAD: begin
                    n_sum_a              = add_a;
                    n_sum_b              = add_b;
                    n_count              = r_count + 16'd1;
                    o_res_valid          = 1'b1;
                    o_res.kind           = ubxfr_pkg::KIND_PAYLOAD;
                    o_res.data_byte      = r_in_byte;
                    o_res.payload_index  = r_count;
                    o_res.msg_class      = r_class;
                    o_res.msg_id         = r_id;
                    o_res.payload_length = r_len;
                    o_res.frame_status   = ubxfr_pkg::ST_OK;
                    if (last_byte) begin
                        n_phase = ubxfr_pkg::PH_CK_A;
                    end
                end
                ubxfr_pkg::PH_CK_A: begin
                    n_rx_sum_a = r_in_byte;
                    n_phase    = ubxfr_pkg::PH_CK_B;
                end
                ubxfr_pkg::PH_CK_B: begin
                    n_phase              = ubxfr_pkg::PH_SYNC1;
                    o_res_valid          = 1'b1;
                    o_res.kind           = ubxfr_pkg::KIND_STATUS;
                    o_res.msg_class      = r_class;
                    o_res.msg_id         = r_id;
                    o_res.payload_length = r_len;
                    o_res.frame_status   = ubxfr_pkg::ST_OK;
                    if (i_cfg.ck_en && (r_rx_sum_a != r_sum_a || r_in_byte != r_sum_b)) begin
                        o_res.frame_status = ubxfr_pkg::ST_CHECKSUM;
                    end
                end
                default: begin
                    n_phase = (r_in_byte == ubxfr_pkg::SYNC_FIRST) ?
                              ubxfr_pkg::PH_SYNC2 : ubxfr_pkg::PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= ubxfr_pkg::PH_SYNC1;
        end else begin
            r_in_valid <= i_valid;
            r_phase    <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_in_byte <= i_byte;
        end
        r_class    <= n_class;
        r_id       <= n_id;
        r_len      <= n_len;
        r_count    <= n_count;
        r_sum_a    <= n_sum_a;
        r_sum_b    <= n_sum_b;
        r_rx_sum_a <= n_rx_sum_a;
    end

    `ASSERT_SAME(a_payload_out, i_clk, i_rst_n, r_in_valid && r_phase == ubxfr_pkg::PH_PAYLOAD, o_res_valid && o_res.kind == ubxfr_pkg::KIND_PAYLOAD)
    `ASSERT_NEXT(a_ckb_ends, i_clk, i_rst_n, r_in_valid && r_phase == ubxfr_pkg::PH_CK_B, r_phase == ubxfr_pkg::PH_SYNC1)
    `ASSERT_SAME(a_idle_quiet, i_clk, i_rst_n, !r_in_valid, !o_res_valid)

endmodule

FILE: hdl/ubxfr_out_queue.sv
// three-entry result queue between the frame state machine and the output port
// depends on ubxfr_pkg and assert_macros.svh
`include "assert_macros.svh"
module ubxfr_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ubxfr_pkg::t_result  i_data,
    input  logic                i_stall,
    output logic                o_valid,
    output ubxfr_pkg::t_result  o_data,
    output logic [1:0]          o_level
);

    ubxfr_pkg::t_result r_mem [3];
    logic [1:0] r_head, n_head;
    logic [1:0] r_tail, n_tail;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_head];
    assign o_level = r_count;
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_head  = pop ? ((r_head == 2'd2) ? 2'd0 : r_head + 2'd1) : r_head;
        n_tail  = i_push ? ((r_tail == 2'd2) ? 2'd0 : r_tail + 2'd1) : r_tail;
        n_count = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    // the input stall keeps one free slot for the byte in flight
    `ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, i_push, r_count != 2'd3 || pop)
    `ASSERT_NEXT(a_count_follows, i_clk, i_rst_n, i_push && !pop, r_count == $past(r_count) + 2'd1)

endmodule

FILE: hdl/ubx_frame_receiver.sv
// top level of the ubx frame receiver
// depends on ubxfr_pkg, ubxfr_cfg_regs, ubxfr_decoder, ubxfr_out_queue
// Takes one received byte per clock cycle while not stalled and finds ubx frames
// (sync 0xB5 0x62, class, id, 16-bit little-endian length, payload, fletcher-8
// checksum A then B). Each payload byte comes out as a payload result with its index;
// each frame, and each sync, class or length failure, ends in one status result with
// last set. A byte is registered on acceptance and its result lands in a three-entry
// output queue the next cycle, from whose head it is visible. The input stalls only
// when the output queue has been held off long enough to fill it; with the output taken
// freely the rate is one byte every cycle. Configuration writes are always ready and
// take effect in the next cycle.
module ubx_frame_receiver (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [7:0]   i_rx_byte,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic         o_result_kind,
    output logic [7:0]   o_data_byte,
    output logic [15:0]  o_payload_index,
    output logic [7:0]   o_msg_class,
    output logic [7:0]   o_msg_id,
    output logic [15:0]  o_payload_length,
    output logic [2:0]   o_frame_status,
    output logic         o_last,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    ubxfr_pkg::t_cfg    cfg;
    ubxfr_pkg::t_result res;
    ubxfr_pkg::t_result head;
    logic               res_valid;
    logic               busy;
    logic [1:0]         level;
    logic               accept;

    // queue plus the byte in flight must leave room for one more request
    assign o_in_stall = ({1'b0, level} + {2'b00, busy}) >= 3'd3;
    assign accept     = i_in_valid && !o_in_stall;

    ubxfr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_ready (o_cfg_ready),
        .o_cfg   (cfg)
    );

    ubxfr_decoder u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_byte      (i_rx_byte),
        .i_cfg       (cfg),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    ubxfr_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (head),
        .o_level (level)
    );

    assign o_result_kind    = head.kind;
    assign o_data_byte      = head.data_byte;
    assign o_payload_index  = head.payload_index;
    assign o_msg_class      = head.msg_class;
    assign o_msg_id         = head.msg_id;
    assign o_payload_length = head.payload_length;
    assign o_frame_status   = head.frame_status;
    assign o_last           = head.kind;

endmodule
